/* hdl/assert_macros.svh */
// Assertion macros shared by the console writer RTL.
// Standalone header; included by files that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(name, clock, resetn, ante, cons) \
    name: assert property (@(posedge clock) disable iff (!resetn) (ante) |-> (cons)) \
        else $error("%m: same-cycle implication failed");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(name, clock, resetn, ante, cons) \
    name: assert property (@(posedge clock) disable iff (!resetn) (ante) |=> (cons)) \
        else $error("%m: next-cycle implication failed");

`endif

/* hdl/tccw_pkg.sv */
// Package for the text console character writer: result types, codes, constants.
// No dependencies; used by tccw_step, tccw_queue and text_console_char_writer.
`default_nettype none

package tccw_pkg;

    localparam int COLUMNS_DEF = 80;
    localparam int ROWS_DEF    = 25;

    localparam int MAX_RESULTS = 7;
    localparam int CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int POS_W       = 11;
    localparam int VALUE_W     = 16;

    localparam logic [7:0] CHAR_BACKSPACE = 8'd8;
    localparam logic [7:0] CHAR_TAB       = 8'd9;
    localparam logic [7:0] CHAR_NEWLINE   = 8'd10;
    localparam logic [7:0] CHAR_BLANK     = 8'h20;

    localparam logic [7:0] ATTR_RESET = 8'h0F;

    // APB register map: register index sits above the byte offset bits
    localparam int         PADDR_W       = 3;
    localparam logic [0:0] REG_ATTRIBUTE = 1'b0;

    typedef enum logic [1:0] {
        KIND_WRITE  = 2'd0,
        KIND_CLEAR  = 2'd1,
        KIND_CURSOR = 2'd2
    } kind_t;

    typedef struct packed {
        kind_t                kind;
        logic [POS_W-1:0]     position;
        logic [VALUE_W-1:0]   cell_value;
        logic                 last;
    } result_t;

    function automatic result_t make_result(kind_t k, logic [POS_W-1:0] p,
                                            logic [VALUE_W-1:0] v);
        result_t r;
        r.kind       = k;
        r.position   = p;
        r.cell_value = v;
        r.last       = 1'b0;
        return r;
    endfunction

endpackage

`default_nettype wire

/* hdl/tccw_step.sv */
// Combinational step: one character plus cursor gives the full result list.
// Depends on tccw_pkg.
`default_nettype none

module tccw_step #(
    parameter int COLUMNS = tccw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tccw_pkg::ROWS_DEF
) (
    input  wire logic [7:0]                  character,
    input  wire logic [$clog2(COLUMNS)-1:0]  column,
    input  wire logic [$clog2(ROWS)-1:0]     row,
    input  wire logic [7:0]                  attribute,
    output tccw_pkg::result_t [tccw_pkg::MAX_RESULTS-1:0] list,
    output logic [tccw_pkg::CNT_W-1:0]       count,
    output logic [$clog2(COLUMNS)-1:0]       next_column,
    output logic [$clog2(ROWS)-1:0]          next_row
);

    localparam int CW = $clog2(COLUMNS);
    localparam int RW = $clog2(ROWS);
    localparam int PW = (CW + RW > tccw_pkg::POS_W) ? CW + RW : tccw_pkg::POS_W;

    typedef struct packed {
        logic [CW:0] c;
        logic [RW:0] r;
        logic        clr;
    } settle_t;

    function automatic logic [tccw_pkg::POS_W-1:0] pos_of(logic [CW:0] cc, logic [RW:0] rr);
        logic [PW-1:0] p;
        p = PW'(rr) * PW'(COLUMNS) + PW'(cc);
        return p[tccw_pkg::POS_W-1:0];
    endfunction

    // wrap past the right edge, then clear + home past the bottom
    function automatic settle_t settle(logic [CW:0] cc, logic [RW:0] rr);
        settle_t s;
        s.c   = cc;
        s.r   = rr;
        s.clr = 1'b0;
        if (cc >= (CW+1)'(COLUMNS))
        begin
            s.c = '0;
            s.r = rr + 1'b1;
        end
        if (s.r >= (RW+1)'(ROWS))
        begin
            s.c   = '0;
            s.r   = '0;
            s.clr = 1'b1;
        end
        return s;
    endfunction

    tccw_pkg::result_t [tccw_pkg::MAX_RESULTS-1:0] lst;
    logic [tccw_pkg::CNT_W-1:0] n;
    logic [CW:0]                c;
    logic [RW:0]                r;
    logic [1:0]                 np;
    settle_t                    s;
    logic [15:0]                blank_val;
    logic [15:0]                clear_val;

    assign blank_val = {attribute, tccw_pkg::CHAR_BLANK};
    assign clear_val = {attribute, tccw_pkg::CHAR_BLANK};

    always_comb
    begin
        lst = '0;
        n   = '0;
        c   = {1'b0, column};
        r   = {1'b0, row};
        np  = '0;
        s   = '0;

        unique case (character)
            tccw_pkg::CHAR_NEWLINE:
            begin
                c = '0;
                r = r + 1'b1;
            end
            tccw_pkg::CHAR_BACKSPACE:
            begin
                if (c == '0)
                begin
                    c = (CW+1)'(COLUMNS - 1);
                    r = (r == '0) ? (RW+1)'(ROWS - 1) : r - 1'b1;
                end
                else
                begin
                    c = c - 1'b1;
                end
                lst[n] = tccw_pkg::make_result(tccw_pkg::KIND_WRITE, pos_of(c, r), blank_val);
                n = n + 1'b1;
            end
            tccw_pkg::CHAR_TAB:
            begin
                np = column[0] ? 2'd1 : 2'd2;
                for (int k = 0; k < 2; k++)
                begin
                    if (2'(k) < np)
                    begin
                        lst[n] = tccw_pkg::make_result(tccw_pkg::KIND_WRITE, pos_of(c, r),
                                                       blank_val);
                        n = n + 1'b1;
                        c = c + 1'b1;
                        s = settle(c, r);
                        c = s.c;
                        r = s.r;
                        if (s.clr)
                        begin
                            lst[n] = tccw_pkg::make_result(tccw_pkg::KIND_CLEAR, '0, clear_val);
                            n = n + 1'b1;
                            lst[n] = tccw_pkg::make_result(tccw_pkg::KIND_CURSOR, '0, '0);
                            n = n + 1'b1;
                        end
                        lst[n] = tccw_pkg::make_result(tccw_pkg::KIND_CURSOR, pos_of(c, r), '0);
                        n = n + 1'b1;
                    end
                end
            end
            default:
            begin
                lst[n] = tccw_pkg::make_result(tccw_pkg::KIND_WRITE, pos_of(c, r),
                                               {attribute, character});
                n = n + 1'b1;
                c = c + 1'b1;
            end
        endcase

        // closing settle, common to every character
        s = settle(c, r);
        c = s.c;
        r = s.r;
        if (s.clr)
        begin
            lst[n] = tccw_pkg::make_result(tccw_pkg::KIND_CLEAR, '0, clear_val);
            n = n + 1'b1;
            lst[n] = tccw_pkg::make_result(tccw_pkg::KIND_CURSOR, '0, '0);
            n = n + 1'b1;
        end
        lst[n] = tccw_pkg::make_result(tccw_pkg::KIND_CURSOR, pos_of(c, r), '0);
        lst[n].last = 1'b1;
        n = n + 1'b1;
    end

    assign list        = lst;
    assign count       = n;
    assign next_column = c[CW-1:0];
    assign next_row    = r[RW-1:0];

endmodule

`default_nettype wire

/* hdl/tccw_queue.sv */
// Result queue: holds one character's result list and shifts it out head first.
// Depends on tccw_pkg.
`default_nettype none

module tccw_queue (
    input  wire logic                                    clk,
    input  wire logic                                    rst_n,
    input  wire logic                                    load,
    input  wire tccw_pkg::result_t [tccw_pkg::MAX_RESULTS-1:0] load_list,
    input  wire logic [tccw_pkg::CNT_W-1:0]              load_count,
    input  wire logic                                    shift,
    output logic                                         free,
    output logic                                         head_valid,
    output tccw_pkg::result_t                            head
);

    tccw_pkg::result_t [tccw_pkg::MAX_RESULTS-1:0] entries_reg, entries_next;
    logic [tccw_pkg::CNT_W-1:0]                    count_reg, count_next;

    // free to take a new list this cycle: empty, or last entry leaving now
    assign free       = (count_reg == '0) || ((count_reg == tccw_pkg::CNT_W'(1)) && shift);
    assign head_valid = (count_reg != '0);
    assign head       = entries_reg[0];

    always_comb
    begin
        count_next   = count_reg;
        entries_next = entries_reg;
        if (load)
        begin
            count_next   = load_count;
            entries_next = load_list;
        end
        else if (shift)
        begin
            count_next = count_reg - 1'b1;
            for (int i = 0; i < tccw_pkg::MAX_RESULTS - 1; i++)
            begin
                entries_next[i] = entries_reg[i+1];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
        end
        else
        begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        entries_reg <= entries_next;
    end

endmodule

`default_nettype wire

/* hdl/text_console_char_writer.sv */
// Top level of the text console character writer: input register, cursor, config.
// Depends on tccw_pkg, tccw_step, tccw_queue and assert_macros.svh.
//
//   channel | signals                         | direction | moves per transaction
//   --------+---------------------------------+-----------+----------------------
//   in      | in_valid/in_stall, character    | to block  | one character byte
//   out     | out_valid/out_stall, kind,      | from block| one result (write,
//           | position, cell_value, last      |           | clear or cursor)
//   apb     | psel/penable/pwrite/paddr/...   | to block  | attribute register
//
// Results: a character gives 1 to 7, one per output transaction: a newline 1,
//   a printable character or backspace 2, a tab 3 or 5; a scroll off the bottom
//   (never on a backspace) adds 2 more for the clear and the home update.
// The result queue sets the rate: it loads a character's whole list at once and
//   drains one entry per cycle while out_stall is low; meanwhile the input
//   register holds the next, which enters the queue once the queue is free.
// Reset homes the cursor and sets attribute to 0x0F; out_stall only holds the
//   queue head and, once the queue cannot load, backs up into in_stall.
`default_nettype none
`include "assert_macros.svh"

module text_console_char_writer #(
    parameter int COLUMNS = tccw_pkg::COLUMNS_DEF,
    parameter int ROWS    = tccw_pkg::ROWS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // input channel
    input  wire logic                          in_valid,
    output logic                               in_stall,
    input  wire logic [7:0]                    character,
    // output channel
    output logic                               out_valid,
    input  wire logic                          out_stall,
    output logic [1:0]                         kind,
    output logic [tccw_pkg::POS_W-1:0]         position,
    output logic [tccw_pkg::VALUE_W-1:0]       cell_value,
    output logic                               last,
    // configuration port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [tccw_pkg::PADDR_W-1:0]  paddr,
    input  wire logic [31:0]                   pwdata,
    output logic [31:0]                        prdata,
    output logic                               pready
);

    localparam int CW = $clog2(COLUMNS);
    localparam int RW = $clog2(ROWS);

    // input register
    logic       in_valid_reg, in_valid_next;
    logic [7:0] char_reg, char_next;

    // cursor and attribute
    logic [CW-1:0] col_reg, col_next;
    logic [RW-1:0] row_reg, row_next;
    logic [7:0]    attr_reg, attr_next;

    // step results
    tccw_pkg::result_t [tccw_pkg::MAX_RESULTS-1:0] step_list;
    logic [tccw_pkg::CNT_W-1:0]                    step_count;
    logic [CW-1:0]                                 step_col;
    logic [RW-1:0]                                 step_row;

    logic              q_free;
    logic              q_load;
    logic              out_xfer;
    logic              in_xfer;
    logic              cfg_write;
    logic              reg_hit;
    tccw_pkg::result_t head;

    tccw_step #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_step (
        .character   (char_reg),
        .column      (col_reg),
        .row         (row_reg),
        .attribute   (attr_reg),
        .list        (step_list),
        .count       (step_count),
        .next_column (step_col),
        .next_row    (step_row)
    );

    tccw_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .load       (q_load),
        .load_list  (step_list),
        .load_count (step_count),
        .shift      (out_xfer),
        .free       (q_free),
        .head_valid (out_valid),
        .head       (head)
    );

    // output transaction pops the queue head
    assign out_xfer   = out_valid && !out_stall;
    assign kind       = head.kind;
    assign position   = head.position;
    assign cell_value = head.cell_value;
    assign last       = head.last;

    // held character moves into the queue as soon as it has room
    assign q_load   = in_valid_reg && q_free;
    assign in_stall = in_valid_reg && !q_free;
    assign in_xfer  = in_valid && !in_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        char_next     = char_reg;
        if (in_xfer)
        begin
            in_valid_next = 1'b1;
            char_next     = character;
        end
        else if (q_load)
        begin
            in_valid_next = 1'b0;
        end
    end

    // cursor advances when a character's list is committed to the queue
    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (q_load)
        begin
            col_next = step_col;
            row_next = step_row;
        end
    end

    // APB: single attribute register, always ready
    assign pready    = 1'b1;
    assign reg_hit   = (paddr[tccw_pkg::PADDR_W-1:2] == tccw_pkg::REG_ATTRIBUTE);
    assign cfg_write = psel && penable && pwrite && reg_hit;
    assign attr_next = cfg_write ? pwdata[7:0] : attr_reg;
    assign prdata    = reg_hit ? {24'b0, attr_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
            col_reg      <= '0;
            row_reg      <= '0;
            attr_reg     <= tccw_pkg::ATTR_RESET;
        end
        else
        begin
            in_valid_reg <= in_valid_next;
            col_reg      <= col_next;
            row_reg      <= row_next;
            attr_reg     <= attr_next;
        end
    end

    always_ff @(posedge clk)
    begin
        char_reg <= char_next;
    end

    // a stall on the input only ever comes from a held character
    `ASSERT_IMPLIES(a_stall_needs_held, clk, rst_n, in_stall, in_valid_reg)
    // a result that is not the last of its character is followed by another
    `ASSERT_NEXT(a_run_continues, clk, rst_n, out_xfer && !last, out_valid)
    // a screen clear is always followed by a home cursor update
    `ASSERT_NEXT(a_clear_then_home, clk, rst_n,
        out_xfer && (kind == tccw_pkg::KIND_CLEAR),
        out_valid && (kind == tccw_pkg::KIND_CURSOR) && (position == '0))

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for text_console_char_writer: directed and random characters,
// attribute register traffic over APB, idle/stall phases and a long output hold-off.
// Depends on tccw_pkg and the text_console_char_writer RTL.

module tb_top;

    localparam int COLS          = tccw_pkg::COLUMNS_DEF;
    localparam int LINES         = tccw_pkg::ROWS_DEF;
    localparam int DRAIN_CYCLES  = 12;    // idle wait after the last expected result
    localparam int QUIET_LIMIT   = 2000;  // watchdog: cycles with no transaction
    localparam int HOLD_CYCLES   = 300;   // long output hold-off for the pressure test
    localparam logic [tccw_pkg::PADDR_W-1:0] ADDR_ATTRIBUTE =
        {tccw_pkg::REG_ATTRIBUTE, 2'b00};

    // clock and reset
    logic clk = 1'b0;
    logic rst_n = 1'b0;

    // input channel
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [7:0] character = 8'h00;

    // output channel
    logic                           out_valid;
    logic                           out_stall = 1'b0;
    logic [1:0]                     kind;
    logic [tccw_pkg::POS_W-1:0]     position;
    logic [tccw_pkg::VALUE_W-1:0]   cell_value;
    logic                           last;

    // APB
    logic                         psel = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite = 1'b0;
    logic [tccw_pkg::PADDR_W-1:0] paddr = '0;
    logic [31:0]                  pwdata = '0;
    logic [31:0]                  prdata;
    logic                         pready;

    // testbench copy of the block's state
    int         cur_col;
    int         cur_row;
    logic [7:0] attr_shadow;

    tccw_pkg::result_t expected_results[$];
    int                error_count = 0;

    // idle knobs, percent per cycle
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_left = 0;

    text_console_char_writer dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_stall   (in_stall),
        .character  (character),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .kind       (kind),
        .position   (position),
        .cell_value (cell_value),
        .last       (last),
        .psel       (psel),
        .penable    (penable),
        .pwrite     (pwrite),
        .paddr      (paddr),
        .pwdata     (pwdata),
        .prdata     (prdata),
        .pready     (pready)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Screen predictor: cursor walk and the result list for one character
    // ------------------------------------------------------------------
    function automatic void push_result(tccw_pkg::kind_t k, int pos,
                                        logic [tccw_pkg::VALUE_W-1:0] v);
        tccw_pkg::result_t r;
        r.kind       = k;
        r.position   = pos[tccw_pkg::POS_W-1:0];
        r.cell_value = v;
        r.last       = 1'b0;
        expected_results.push_back(r);
    endfunction

    // Wrap off the right edge, clear + home off the bottom, then report the cursor.
    function automatic void settle_cursor();
        if (cur_col >= COLS)
        begin
            cur_col = 0;
            cur_row++;
        end
        if (cur_row >= LINES)
        begin
            cur_col = 0;
            cur_row = 0;
            push_result(tccw_pkg::KIND_CLEAR, 0, {attr_shadow, tccw_pkg::CHAR_BLANK});
            push_result(tccw_pkg::KIND_CURSOR, 0, '0);
        end
        push_result(tccw_pkg::KIND_CURSOR, cur_row * COLS + cur_col, '0);
    endfunction

    function automatic void print_cell(logic [7:0] ch);
        push_result(tccw_pkg::KIND_WRITE, cur_row * COLS + cur_col, {attr_shadow, ch});
        cur_col++;
        settle_cursor();
    endfunction

    function automatic void predict_char(logic [7:0] ch);
        int spaces;
        if (ch == tccw_pkg::CHAR_NEWLINE)
        begin
            cur_col = 0;
            cur_row++;
            settle_cursor();
        end
        else if (ch == tccw_pkg::CHAR_BACKSPACE)
        begin
            // step back; from the top-left it lands on the bottom-right corner
            if (cur_col == 0)
            begin
                cur_col = COLS - 1;
                cur_row = (cur_row == 0) ? LINES - 1 : cur_row - 1;
            end
            else
                cur_col--;
            push_result(tccw_pkg::KIND_WRITE, cur_row * COLS + cur_col,
                        {attr_shadow, tccw_pkg::CHAR_BLANK});
            settle_cursor();
        end
        else if (ch == tccw_pkg::CHAR_TAB)
        begin
            // two spaces from an even column, one from an odd one
            spaces = (cur_col % 2 == 0) ? 2 : 1;
            for (int i = 0; i < spaces; i++)
                print_cell(tccw_pkg::CHAR_BLANK);
            settle_cursor();
        end
        else
            print_cell(ch);
        expected_results[expected_results.size() - 1].last = 1'b1;
    endfunction

    // ------------------------------------------------------------------
    // Output side: random stall, optional long hold-off, and the checker
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        tccw_pkg::result_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_results.size() == 0)
            begin
                $display("%0t: unexpected result kind=%0d position=%0d cell_value=%h last=%b",
                         $time, kind, position, cell_value, last);
                error_count++;
            end
            else
            begin
                want = expected_results.pop_front();
                if (want.kind !== kind)
                begin
                    $display("%0t: kind mismatch: expected %0d, actual %0d",
                             $time, want.kind, kind);
                    error_count++;
                end
                if (want.position !== position)
                begin
                    $display("%0t: position mismatch: expected %0d, actual %0d",
                             $time, want.position, position);
                    error_count++;
                end
                if (want.cell_value !== cell_value)
                begin
                    $display("%0t: cell_value mismatch: expected %h, actual %h",
                             $time, want.cell_value, cell_value);
                    error_count++;
                end
                if (want.last !== last)
                begin
                    $display("%0t: last mismatch: expected %b, actual %b",
                             $time, want.last, last);
                    error_count++;
                end
            end
        end
        if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
            out_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Watchdog: any cycle with no transaction on any port counts toward the limit.
    always @(posedge clk)
    begin
        int quiet;
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable))
            quiet = 0;
        else
            quiet++;
        if (quiet >= QUIET_LIMIT)
        begin
            $display("%0t: watchdog expired, %0d results outstanding",
                     $time, expected_results.size());
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Shared driver tasks
    // ------------------------------------------------------------------
    // One input transaction. Each cycle before it the sender idles with the
    // phase's odds; with no idle drawn, valid never drops between characters.
    task automatic send_char(input logic [7:0] ch);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid  <= 1'b0;
            character <= 8'($urandom_range(255));
            @(posedge clk);
        end
        in_valid  <= 1'b1;
        character <= ch;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        predict_char(ch);
    endtask

    // Stop sending, wait for every expected result, then let the pipeline go quiet.
    task automatic drain();
        in_valid <= 1'b0;
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_attribute(input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_ATTRIBUTE;
        pwdata  <= {24'h0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);      // access: written here, pready is tied high
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        attr_shadow = value;
        @(posedge clk);
    endtask

    task automatic check_attribute_readback();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= ADDR_ATTRIBUTE;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== {24'h0, attr_shadow})
        begin
            $display("%0t: attribute readback mismatch: expected %h, actual %h",
                     $time, {24'h0, attr_shadow}, prdata);
            error_count++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    // Random character mix: control codes weighted up, the rest any byte.
    function automatic logic [7:0] pick_char(int newline_pct);
        int roll;
        roll = $urandom_range(99);
        if (roll < newline_pct)
            return tccw_pkg::CHAR_NEWLINE;
        if (roll < newline_pct + 12)
            return tccw_pkg::CHAR_BACKSPACE;
        if (roll < newline_pct + 24)
            return tccw_pkg::CHAR_TAB;
        return 8'($urandom_range(255));
    endfunction

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Reset value, then both extremes of the attribute byte.
    task automatic test_register_access();
        check_attribute_readback();
        write_attribute(8'h00);
        check_attribute_readback();
        write_attribute(8'hFF);
        check_attribute_readback();
        write_attribute(tccw_pkg::ATTR_RESET);
    endtask

    // Cursor edge cases starting from home, no idling.
    task automatic test_directed();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_char(tccw_pkg::CHAR_BACKSPACE);  // top-left wraps to bottom-right corner
        send_char(8'h78);                     // print at the corner: off the bottom, clear
        send_char(tccw_pkg::CHAR_BACKSPACE);
        send_char(tccw_pkg::CHAR_NEWLINE);    // newline on the last row clears
        send_char(tccw_pkg::CHAR_BACKSPACE);
        send_char(tccw_pkg::CHAR_BACKSPACE);  // column 78, last row
        send_char(tccw_pkg::CHAR_TAB);        // even-column tab that clears mid-way
        send_char(8'h00);                     // character zero prints
        send_char(tccw_pkg::CHAR_TAB);        // odd column: one space
        send_char(tccw_pkg::CHAR_TAB);        // even column: two spaces
        send_char(8'hFF);
        send_char(8'h7F);
        send_char(8'h80);
        send_char(tccw_pkg::CHAR_NEWLINE);
        send_char(tccw_pkg::CHAR_BACKSPACE);  // column 0 of row 1 goes back to row 0
        send_char(8'h41);                     // wrap off the right edge to row 1
        send_char(tccw_pkg::CHAR_BACKSPACE);
        send_char(8'h0B);
        send_char(8'h07);
        send_char(8'h0D);
        send_char(8'h20);
        send_char(tccw_pkg::CHAR_NEWLINE);
        send_char(tccw_pkg::CHAR_BACKSPACE);
        send_char(tccw_pkg::CHAR_TAB);        // tab from the last column wraps
        drain();
    endtask

    task automatic test_random_phase(input int idle_pct, input int stall_pct,
                                     input logic [7:0] attr, input int count,
                                     input int newline_pct);
        write_attribute(attr);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        for (int i = 0; i < count; i++)
            send_char(pick_char(newline_pct));
        drain();
    endtask

    // Output held off for a long stretch while characters keep coming, so the
    // result queue fills and in_stall rises.
    task automatic test_output_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        hold_left      = HOLD_CYCLES;
        for (int i = 0; i < 20; i++)
            send_char(pick_char(10));
        drain();
    endtask

    initial
    begin
        cur_col     = 0;
        cur_row     = 0;
        attr_shadow = tccw_pkg::ATTR_RESET;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_register_access();
        test_directed();
        test_random_phase(0, 0, 8'h00, 17, 10);
        test_random_phase(59, 0, 8'hFF, 17, 30);
        test_random_phase(0, 59, 8'($urandom_range(255)), 17, 10);
        test_random_phase(37, 37, 8'hA5, 17, 30);
        test_output_backpressure();
        check_attribute_readback();

        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end

endmodule

/* text_console_char_writer.f */
+incdir+hdl
hdl/tccw_pkg.sv
hdl/tccw_step.sv
hdl/tccw_queue.sv
hdl/text_console_char_writer.sv
tb/sv/tb_top.sv
